### hw/rtl/edbp_pkg.sv
// Shared types and constants of the Elias delta bit packer.
package edbp_pkg;

  localparam int WORD_BITS   = 32;                    // packed word width
  localparam int VALUE_W     = 32;                    // input value width
  localparam int CODE_MAX    = 42;                    // longest code in bits
  localparam int CODE_W      = 38;                    // code as an integer
  localparam int LEN_W       = 6;                     // code length field
  localparam int FILL_W      = 5;                     // accumulator fill count
  localparam int VB_W        = 6;                     // valid_bits field
  localparam int TOTAL_W     = 7;                     // fill plus code length
  localparam int WIN_W       = WORD_BITS + CODE_MAX;  // merge window
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = 2;

  // One coded item on its way to the accumulator.
  typedef struct packed {
    logic [CODE_W-1:0] code;   // code bits, right aligned
    logic [LEN_W-1:0]  len;    // number of code bits
    logic              last;   // flush after this item
    logic              bad;    // value was zero
  } code_t;

  // One result transaction.
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [VB_W-1:0]      valid_bits;
    logic                 stream_end;
    logic                 bad_value;
  } result_t;

  // All results caused by one item, first result in entry 0.
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [CNT_W-1:0]          count;
  } bundle_t;

endpackage

### hw/rtl/edbp_coder.sv
// Elias delta coder: bit length, length of length and right-aligned code.
module edbp_coder (
  input  logic [edbp_pkg::VALUE_W-1:0] value_i,
  input  logic                         last_i,
  output edbp_pkg::code_t              code_o
);

  logic [edbp_pkg::VALUE_W-1:0] x;
  logic [5:0]                   lz;
  logic [5:0]                   k;
  logic [4:0]                   km1;
  logic [2:0]                   p;
  logic [edbp_pkg::CODE_W-1:0]  term;

  always_comb begin
    // count leading zeros in five halving steps
    x  = value_i;
    lz = 6'd0;
    if (x[31:16] == 16'd0) begin
      lz = lz + 6'd16;
      x  = {x[15:0], 16'd0};
    end
    if (x[31:24] == 8'd0) begin
      lz = lz + 6'd8;
      x  = {x[23:0], 8'd0};
    end
    if (x[31:28] == 4'd0) begin
      lz = lz + 6'd4;
      x  = {x[27:0], 4'd0};
    end
    if (x[31:30] == 2'd0) begin
      lz = lz + 6'd2;
      x  = {x[29:0], 2'd0};
    end
    if (x[31] == 1'b0) begin
      lz = lz + 6'd1;
    end
    k   = 6'd32 - lz;
    km1 = 5'(k - 6'd1);

    priority if (k[5]) p = 3'd6;
    else if (k[4])     p = 3'd5;
    else if (k[3])     p = 3'd4;
    else if (k[2])     p = 3'd3;
    else if (k[1])     p = 3'd2;
    else               p = 3'd1;

    // the leading one of the value turns into k once (k-1) is added above it
    term = {{(edbp_pkg::CODE_W-5){1'b0}}, km1} << km1;

    code_o.code = {{(edbp_pkg::CODE_W-edbp_pkg::VALUE_W){1'b0}}, value_i} + term;
    code_o.len  = {2'b00, p, 1'b0} + k - 6'd2;
    code_o.last = last_i;
    code_o.bad  = (value_i == '0);
  end

endmodule

### hw/rtl/edbp_packer.sv
// Word accumulator: merges one code per cycle while advance_i is high and forms its result bundle.
module edbp_packer (
  input  logic              clk,
  input  logic              rst_n,
  input  edbp_pkg::code_t   code_i,
  input  logic              advance_i,
  output edbp_pkg::bundle_t bundle_o
);

  localparam int WordBits = edbp_pkg::WORD_BITS;
  localparam int WinW     = edbp_pkg::WIN_W;
  localparam int TailW    = WinW - 2 * WordBits;

  logic [WordBits-1:0]         partial_r, partial_nxt;
  logic [edbp_pkg::FILL_W-1:0] fill_r, fill_nxt;

  logic [edbp_pkg::TOTAL_W-1:0] total;
  logic [edbp_pkg::TOTAL_W-1:0] shift;
  logic [WinW-1:0]              window;
  logic [WordBits-1:0]          word0, word1, tail, pre;
  logic [1:0]                   nfull;
  logic [edbp_pkg::FILL_W-1:0]  rem;
  logic [edbp_pkg::VB_W-1:0]    vb_full;

  always_comb begin
    vb_full = edbp_pkg::VB_W'(WordBits);
    total   = edbp_pkg::TOTAL_W'(fill_r) + edbp_pkg::TOTAL_W'(code_i.len);
    shift   = edbp_pkg::TOTAL_W'(WinW) - total;
    window  = {partial_r, {edbp_pkg::CODE_MAX{1'b0}}}
            | ({{(WinW-edbp_pkg::CODE_W){1'b0}}, code_i.code} << shift);
    word0   = window[WinW-1 -: WordBits];
    word1   = window[WinW-WordBits-1 -: WordBits];
    tail    = {window[TailW-1:0], {(WordBits-TailW){1'b0}}};
    rem     = total[edbp_pkg::FILL_W-1:0];

    priority if (total[6]) nfull = 2'd2;
    else if (total[5])     nfull = 2'd1;
    else                   nfull = 2'd0;

    unique case (nfull)
      2'd0:    pre = word0;
      2'd1:    pre = word1;
      2'd2:    pre = tail;
      default: pre = '0;
    endcase

    bundle_o                     = '0;
    bundle_o.res[0].word         = word0;
    bundle_o.res[0].valid_bits   = vb_full;
    bundle_o.res[1].word         = word1;
    bundle_o.res[1].valid_bits   = vb_full;
    partial_nxt                  = partial_r;
    fill_nxt                     = fill_r;

    if (code_i.bad) begin
      // zero value: lone error result, accumulator untouched
      bundle_o.res[0]           = '0;
      bundle_o.res[0].bad_value = 1'b1;
      bundle_o.count            = 2'd1;
    end else if (code_i.last && rem != '0) begin
      // flush the zero-padded partial word behind the full ones
      unique case (nfull)
        2'd0:    bundle_o.res[0] = '{word: pre, valid_bits: edbp_pkg::VB_W'(rem),
                                     stream_end: 1'b1, bad_value: 1'b0};
        2'd1:    bundle_o.res[1] = '{word: pre, valid_bits: edbp_pkg::VB_W'(rem),
                                     stream_end: 1'b1, bad_value: 1'b0};
        2'd2:    bundle_o.res[2] = '{word: pre, valid_bits: edbp_pkg::VB_W'(rem),
                                     stream_end: 1'b1, bad_value: 1'b0};
        default: bundle_o.res[2] = '0;
      endcase
      bundle_o.count = nfull + 2'd1;
      partial_nxt    = '0;
      fill_nxt       = '0;
    end else if (code_i.last) begin
      // code ended on a word boundary: mark the last full word
      unique case (nfull)
        2'd1:    bundle_o.res[0].stream_end = 1'b1;
        2'd2:    bundle_o.res[1].stream_end = 1'b1;
        default: bundle_o.res[2].stream_end = 1'b0;
      endcase
      bundle_o.count = nfull;
      partial_nxt    = '0;
      fill_nxt       = '0;
    end else begin
      bundle_o.count = nfull;
      partial_nxt    = pre;
      fill_nxt       = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      fill_r    <= '0;
    end else if (advance_i) begin
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
    end
  end

endmodule

### hw/rtl/edbp_out_buf.sv
// Result buffer: holds one item's results and hands them out one per transaction.
module edbp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  edbp_pkg::bundle_t bundle_i,
  input  logic              bundle_valid_i,
  output logic              accept_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output edbp_pkg::result_t result_o
);

  localparam int N = edbp_pkg::MAX_RESULTS;

  edbp_pkg::result_t [N-1:0]    ent_r, ent_nxt;
  logic [edbp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         take;
  logic                         free;
  logic                         load;

  always_comb begin
    take     = (cnt_r != '0) && out_ready_i;
    free     = (cnt_r == '0) || ((cnt_r == 2'd1) && take);
    // an item without results passes straight through
    accept_o = bundle_valid_i && ((bundle_i.count == '0) || free);
    load     = accept_o && (bundle_i.count != '0);

    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      ent_nxt = bundle_i.res;
      cnt_nxt = bundle_i.count;
    end else if (take) begin
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end

    out_valid_o = (cnt_r != '0);
    result_o    = ent_r[0];
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/elias_delta_bit_packer.sv
// Path: input register, stage 2, result buffer; the earliest output transaction for a
//   value's first result completes at the next rising edge after it is offered.
// Throughput: one value per cycle if out_tready is high and each value yields at most
//   one result; a value that fills two words (or fills and flushes) holds the result
//   buffer till each result is taken; one output port moves one word per transaction.
// Reset: synchronous, active low; empties the pipeline and the result buffer and
//   clears the word accumulator.
module elias_delta_bit_packer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value
  input  logic        in_tlast,    // last: flush partial word after this value
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] word, [37:32] valid_bits, [39:38] zero
  output logic        out_tlast,   // stream_end
  output logic        out_tuser    // bad_value
);

  // Stage 1: input register
  logic                         v1_r, v1_nxt;
  logic [edbp_pkg::VALUE_W-1:0] value1_r;
  logic                         last1_r;

  // Stage 2: coded item waiting for the accumulator
  logic                         v2_r, v2_nxt;
  edbp_pkg::code_t              code2_r;

  edbp_pkg::code_t              code1;
  edbp_pkg::bundle_t            bundle;
  edbp_pkg::result_t            result;
  logic                         in_take;
  logic                         ready2;
  logic                         adv1;
  logic                         adv2;

  // Encode from the input register.
  edbp_coder u_coder (
    .value_i (value1_r),
    .last_i  (last1_r),
    .code_o  (code1)
  );

  // Merge the code into the accumulator; state advances only when the bundle is taken.
  edbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .code_i    (code2_r),
    .advance_i (adv2),
    .bundle_o  (bundle)
  );

  // Hold results and serialize them onto the output.
  edbp_out_buf u_out_buf (
    .clk            (clk),
    .rst_n          (rst_n),
    .bundle_i       (bundle),
    .bundle_valid_i (v2_r),
    .accept_o       (adv2),
    .out_valid_o    (out_tvalid),
    .out_ready_i    (out_tready),
    .result_o       (result)
  );

  // Pipeline control: each stage advances when the next one drains or is empty.
  always_comb begin
    ready2    = !v2_r || adv2;
    adv1      = v1_r && ready2;
    in_tready = !v1_r || ready2;
    in_take   = in_tvalid && in_tready;

    v1_nxt = in_take ? 1'b1 : (adv1 ? 1'b0 : v1_r);
    v2_nxt = adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // Payload registers: load on advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      value1_r <= in_tdata;
      last1_r  <= in_tlast;
    end
    if (adv1) begin
      code2_r <= code1;
    end
  end

  // Pack the result transaction.
  assign out_tdata = {2'b00, result.valid_bits, result.word};
  assign out_tlast = result.stream_end;
  assign out_tuser = result.bad_value;

  // An error result carries no code bits.
  a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 40'd0 && !out_tlast)
    else $error("error result carries data");

  // A coded word that does not end a stream is always full.
  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && !out_tlast |-> out_tdata[37:32] == 6'd32)
    else $error("partial word emitted without stream end");

  // A coded item stalled in stage 2 stays there unchanged.
  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !adv2 |=> v2_r && $stable(code2_r))
    else $error("stage 2 item lost or changed while stalled");

endmodule
